// ===== hdl/ibsd_pkg.sv =====
`timescale 1ns / 1ps

package ibsd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [4:0] KIND_NOP     = 5'd0;
    localparam logic [4:0] KIND_HALT    = 5'd1;
    localparam logic [4:0] KIND_RRMOVL  = 5'd2;
    localparam logic [4:0] KIND_IRMOVL  = 5'd3;
    localparam logic [4:0] KIND_RMMOVL  = 5'd4;
    localparam logic [4:0] KIND_MRMOVL  = 5'd5;
    localparam logic [4:0] KIND_ALU     = 5'd6;
    localparam logic [4:0] KIND_JUMP    = 5'd12;
    localparam logic [4:0] KIND_CALL    = 5'd19;
    localparam logic [4:0] KIND_RET     = 5'd20;
    localparam logic [4:0] KIND_PUSHL   = 5'd21;
    localparam logic [4:0] KIND_POPL    = 5'd22;
    localparam logic [4:0] KIND_READ    = 5'd23;
    localparam logic [4:0] KIND_WRITE   = 5'd25;
    localparam logic [4:0] KIND_MOVSBL  = 5'd27;
    localparam logic [4:0] KIND_INVALID = 5'd28;

    localparam logic [3:0] LAST_ALU_FUNC  = 4'd5;
    localparam logic [3:0] LAST_JUMP_FUNC = 4'd6;
    localparam logic [3:0] LAST_IO_FUNC   = 4'd1;

    localparam logic [2:0] LEN_SHORT = 3'd1;
    localparam logic [2:0] LEN_REG   = 3'd2;
    localparam logic [2:0] LEN_IMM   = 3'd5;
    localparam logic [2:0] LEN_FULL  = 3'd6;

    typedef struct packed {
        logic [4:0] kind;
        logic [2:0] len;
    } kind_len_t;

    // one assembled instruction as it moves from the front to the back
    typedef struct packed {
        logic [31:0] address;
        logic [7:0]  opcode;
        logic [7:0]  reg_byte;
        logic [31:0] immediate;
    } instr_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic kind_len_t classify(input logic [7:0] op);
        kind_len_t  r;
        logic [3:0] hi;
        logic [3:0] lo;
        hi     = op[7:4];
        lo     = op[3:0];
        r.kind = KIND_INVALID;
        r.len  = LEN_SHORT;
        case (hi)
            4'h0: if (lo == 4'd0) r = '{KIND_NOP, LEN_SHORT};
            4'h1: if (lo == 4'd0) r = '{KIND_HALT, LEN_SHORT};
            4'h2: if (lo == 4'd0) r = '{KIND_RRMOVL, LEN_REG};
            4'h3: if (lo == 4'd0) r = '{KIND_IRMOVL, LEN_FULL};
            4'h4: if (lo == 4'd0) r = '{KIND_RMMOVL, LEN_FULL};
            4'h5: if (lo == 4'd0) r = '{KIND_MRMOVL, LEN_FULL};
            4'h6: if (lo <= LAST_ALU_FUNC) r = '{KIND_ALU + {1'b0, lo}, LEN_REG};
            4'h7: if (lo <= LAST_JUMP_FUNC) r = '{KIND_JUMP + {1'b0, lo}, LEN_IMM};
            4'h8: if (lo == 4'd0) r = '{KIND_CALL, LEN_IMM};
            4'h9: if (lo == 4'd0) r = '{KIND_RET, LEN_SHORT};
            4'hA: if (lo == 4'd0) r = '{KIND_PUSHL, LEN_REG};
            4'hB: if (lo == 4'd0) r = '{KIND_POPL, LEN_REG};
            4'hC: if (lo <= LAST_IO_FUNC) r = '{KIND_READ + {1'b0, lo}, LEN_FULL};
            4'hD: if (lo <= LAST_IO_FUNC) r = '{KIND_WRITE + {1'b0, lo}, LEN_FULL};
            4'hE: if (lo == 4'd0) r = '{KIND_MOVSBL, LEN_FULL};
            default: r = '{KIND_INVALID, LEN_SHORT};
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/instruction_byte_stream_decoder.sv =====
`timescale 1ns / 1ps

// Decodes a Y86-style code stream one byte per clock. A byte is taken every
// cycle that in_valid is high, no base write is under way and the record queue
// between the byte assembler and the output register has room; an instruction
// of 1, 2, 5 or 6 bytes is pushed as one record into the queue once its last
// byte is taken, and passes from there into the output register. Up to
// QueueDepth records are buffered while the output is stalled, after which
// in_ready drops until a record is taken. Writing cfg_write_data sets the
// address of the next byte and drops any partly received instruction; write
// it only with no bytes in flight. Unknown opcodes give a one-byte record of
// the invalid kind.

module instruction_byte_stream_decoder
    import ibsd_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  code_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] instr_address,
    output logic [4:0]  instr_kind,
    output logic [3:0]  reg_a,
    output logic [3:0]  reg_b,
    output logic [31:0] immediate,
    output logic [2:0]  instr_length
);

    logic          push;
    logic          pop;
    instr_rec_t    push_rec;
    instr_rec_t    head_rec;
    queue_status_t q_status;

    ibsd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .code_byte      (code_byte),
        .queue_full     (q_status.full),
        .push           (push),
        .push_rec       (push_rec)
    );

    ibsd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .status   (q_status)
    );

    ibsd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_rec      (head_rec),
        .status        (q_status),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .instr_address (instr_address),
        .instr_kind    (instr_kind),
        .reg_a         (reg_a),
        .reg_b         (reg_b),
        .immediate     (immediate),
        .instr_length  (instr_length)
    );

    // invalid opcodes always close after one byte with nothing captured
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && instr_kind == KIND_INVALID |->
            instr_length == LEN_SHORT && immediate == 32'd0)
        else $error("invalid record not one byte long");

    // jumps and call never pick up a register byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && instr_length == LEN_IMM |-> reg_a == 4'd0 && reg_b == 4'd0)
        else $error("register nibbles set on immediate-only instruction");

    // one- and two-byte instructions carry no immediate
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (instr_length == LEN_REG || instr_length == LEN_SHORT) |->
            immediate == 32'd0)
        else $error("immediate set on short instruction");

    // the front only pushes a record when the queue has room
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("record pushed into full queue");

endmodule

// ===== hdl/ibsd_front.sv =====
`timescale 1ns / 1ps

module ibsd_front
    import ibsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  code_byte,
    input  logic        queue_full,
    output logic        push,
    output instr_rec_t  push_rec
);

    logic [31:0] next_address_reg, next_address_next;
    logic [31:0] start_address_reg, start_address_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  reg_byte_reg, reg_byte_next;
    logic [31:0] imm_reg, imm_next;
    logic [2:0]  pos_reg, pos_next;
    logic [2:0]  pos_inc;
    logic        accept;
    kind_len_t   cls_new;
    kind_len_t   cls_held;

    // no request is taken in the cycle a new base is written
    assign in_ready = !queue_full && !cfg_write_en;
    assign accept   = in_valid && in_ready;
    assign cls_new  = classify(code_byte);
    assign cls_held = classify(opcode_reg);
    assign pos_inc  = pos_reg + 3'd1;

    always_comb
    begin
        next_address_next  = next_address_reg;
        start_address_next = start_address_reg;
        opcode_next        = opcode_reg;
        reg_byte_next      = reg_byte_reg;
        imm_next           = imm_reg;
        pos_next           = pos_reg;
        push               = 1'b0;
        if (cfg_write_en)
        begin
            next_address_next = cfg_write_data;
            pos_next          = 3'd0;
        end
        else if (accept)
        begin
            next_address_next = next_address_reg + 32'd1;
            if (pos_reg == 3'd0)
            begin
                start_address_next = next_address_reg;
                opcode_next        = code_byte;
                reg_byte_next      = 8'd0;
                imm_next           = 32'd0;
                if (cls_new.len == LEN_SHORT)
                    push = 1'b1;
                else
                    pos_next = 3'd1;
            end
            else
            begin
                // jumps and call carry no register byte
                if (pos_reg == 3'd1 && cls_held.len != LEN_IMM)
                    reg_byte_next = code_byte;
                else
                    imm_next = {code_byte, imm_reg[31:8]};
                if (pos_inc >= cls_held.len)
                begin
                    pos_next = 3'd0;
                    push     = 1'b1;
                end
                else
                    pos_next = pos_inc;
            end
        end
    end

    assign push_rec = '{address:   start_address_next,
                        opcode:    opcode_next,
                        reg_byte:  reg_byte_next,
                        immediate: imm_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_address_reg  <= 32'd0;
            start_address_reg <= 32'd0;
            opcode_reg        <= 8'd0;
            reg_byte_reg      <= 8'd0;
            imm_reg           <= 32'd0;
            pos_reg           <= 3'd0;
        end
        else
        begin
            next_address_reg  <= next_address_next;
            start_address_reg <= start_address_next;
            opcode_reg        <= opcode_next;
            reg_byte_reg      <= reg_byte_next;
            imm_reg           <= imm_next;
            pos_reg           <= pos_next;
        end
    end

endmodule

// ===== hdl/ibsd_queue.sv =====
`timescale 1ns / 1ps

module ibsd_queue
    import ibsd_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  instr_rec_t    push_rec,
    input  logic          pop,
    output instr_rec_t    head_rec,
    output queue_status_t status
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    instr_rec_t            entries_reg [Depth];
    logic [PtrW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]       count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign status.full  = (count_reg == FullCnt);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_rec     = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CntW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CntW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/ibsd_back.sv =====
`timescale 1ns / 1ps

module ibsd_back
    import ibsd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  instr_rec_t    head_rec,
    input  queue_status_t status,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [31:0]   instr_address,
    output logic [4:0]    instr_kind,
    output logic [3:0]    reg_a,
    output logic [3:0]    reg_b,
    output logic [31:0]   immediate,
    output logic [2:0]    instr_length
);

    logic        valid_reg, valid_next;
    logic [31:0] address_reg;
    logic [4:0]  kind_reg;
    logic [3:0]  reg_a_reg;
    logic [3:0]  reg_b_reg;
    logic [31:0] imm_reg;
    logic [2:0]  len_reg;
    kind_len_t   cls;

    assign cls = classify(head_rec.opcode);

    // refill the output slot whenever it is empty or being taken
    assign pop        = !status.empty && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            address_reg <= head_rec.address;
            kind_reg    <= cls.kind;
            reg_a_reg   <= head_rec.reg_byte[7:4];
            reg_b_reg   <= head_rec.reg_byte[3:0];
            imm_reg     <= head_rec.immediate;
            len_reg     <= cls.len;
        end
    end

    assign out_valid     = valid_reg;
    assign instr_address = address_reg;
    assign instr_kind    = kind_reg;
    assign reg_a         = reg_a_reg;
    assign reg_b         = reg_b_reg;
    assign immediate     = imm_reg;
    assign instr_length  = len_reg;

endmodule
